FILE: hw/rtl/e2r_pkg.sv
// e2r_pkg: shared constants and the cordic arctangent table
// used by e2r_cordic, e2r_matrix and euler_to_rotation_matrix; no dependencies
package e2r_pkg;
    localparam int AngW      = 16;
    localparam int OutW      = 16;
    localparam int OutFrac   = 14;
    localparam int WorkFrac  = 30;
    localparam int Steps     = 30;
    localparam int CW        = 34;   // cordic x/y/z width
    localparam int PW        = 68;   // full product width
    localparam logic signed [CW-1:0] GainInit = 34'sd652032874;
    localparam logic signed [CW-1:0] PiW      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HalfPiW  = 34'sd1686629713;

    function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        begin
            unique case (idx)
                5'd0: v = 34'sd843314857;
                5'd1: v = 34'sd497837829;
                5'd2: v = 34'sd263043837;
                5'd3: v = 34'sd133525159;
                5'd4: v = 34'sd67021687;
                5'd5: v = 34'sd33543516;
                5'd6: v = 34'sd16775851;
                5'd7: v = 34'sd8388437;
                5'd8: v = 34'sd4194283;
                5'd9: v = 34'sd2097149;
                default: v = (idx < 5'd30) ? (34'sd1 <<< (5'd30 - idx)) : 34'sd0;
            endcase
            return v;
        end
    endfunction
endpackage

FILE: hw/rtl/e2r_cordic.sv
// e2r_cordic: pipelined rotation-mode cordic, one step per stage, sine and cosine
// depends on e2r_pkg
module e2r_cordic (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [e2r_pkg::AngW-1:0]  i_ang,
    output logic signed [e2r_pkg::CW-1:0]    o_sin,
    output logic signed [e2r_pkg::CW-1:0]    o_cos
);
    localparam int N = e2r_pkg::Steps;
    localparam int W = e2r_pkg::CW;

    logic signed [W-1:0] r_x [N+1];
    logic signed [W-1:0] r_y [N+1];
    logic signed [W-1:0] r_z [N+1];
    logic                r_neg [N+1];
    logic signed [W-1:0] n_z0;
    logic signed [W-1:0] z_in;
    logic                n_neg0;

    // quadrant reflection into the convergence range
    always_comb begin
        z_in = W'(i_ang) <<< 17;
        n_z0 = z_in;
        n_neg0 = 1'b0;
        if (z_in > e2r_pkg::HalfPiW) begin
            n_z0 = e2r_pkg::PiW - z_in;
            n_neg0 = 1'b1;
        end else if (z_in < -e2r_pkg::HalfPiW) begin
            n_z0 = -e2r_pkg::PiW - z_in;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= e2r_pkg::GainInit;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+1] <= r_neg[i];
                if (!r_z[i][W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - e2r_pkg::atan_lut(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + e2r_pkg::atan_lut(5'(i));
                end
            end
        end
    end

    assign o_sin = r_y[N];
    assign o_cos = r_neg[N] ? -r_x[N] : r_x[N];
endmodule

FILE: hw/rtl/e2r_matrix.sv
// e2r_matrix: products, sums, rounding and clamping of the nine entries
// depends on e2r_pkg
module e2r_matrix (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [e2r_pkg::CW-1:0]      i_sb, i_cb, i_sa, i_ca, i_sh, i_ch,
    output logic        [9*e2r_pkg::OutW-1:0]  o_ent
);
    localparam int W  = e2r_pkg::CW;
    localparam int P  = e2r_pkg::PW;
    localparam int WF = e2r_pkg::WorkFrac;
    localparam int SH = e2r_pkg::WorkFrac - e2r_pkg::OutFrac;

    function automatic logic signed [W-1:0] rnd(input logic signed [P-1:0] p);
        logic signed [P-1:0] t;
        begin
            t = (p + (P'(1) <<< (WF-1))) >>> WF;
            return t[W-1:0];
        end
    endfunction

    function automatic logic [e2r_pkg::OutW-1:0] to_out(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        logic signed [W-1:0] one;
        begin
            one = W'(1) <<< e2r_pkg::OutFrac;
            r = (v + (W'(1) <<< (SH-1))) >>> SH;
            if (r > one) r = one;
            if (r < -one) r = -one;
            return r[e2r_pkg::OutW-1:0];
        end
    endfunction

    // stage 1: first products (full width)
    logic signed [P-1:0] r_chsa, r_shsa, r_chca, r_shsb, r_shcb, r_cacb, r_casb,
                         r_shca, r_chsb, r_chcb;
    logic signed [W-1:0] r1_sa, r1_sb, r1_cb;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chsa <= P'(i_ch) * P'(i_sa);
            r_shsa <= P'(i_sh) * P'(i_sa);
            r_chca <= P'(i_ch) * P'(i_ca);
            r_shsb <= P'(i_sh) * P'(i_sb);
            r_shcb <= P'(i_sh) * P'(i_cb);
            r_cacb <= P'(i_ca) * P'(i_cb);
            r_casb <= P'(i_ca) * P'(i_sb);
            r_shca <= P'(i_sh) * P'(i_ca);
            r_chsb <= P'(i_ch) * P'(i_sb);
            r_chcb <= P'(i_ch) * P'(i_cb);
            r1_sa <= i_sa; r1_sb <= i_sb; r1_cb <= i_cb;
        end
    end

    // stage 2: round first products
    logic signed [W-1:0] r2_chsa, r2_shsa, r2_chca, r2_shsb, r2_shcb, r2_cacb, r2_casb,
                         r2_shca, r2_chsb, r2_chcb, r2_sa, r2_sb, r2_cb;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_chsa <= rnd(r_chsa); r2_shsa <= rnd(r_shsa); r2_chca <= rnd(r_chca);
            r2_shsb <= rnd(r_shsb); r2_shcb <= rnd(r_shcb); r2_cacb <= rnd(r_cacb);
            r2_casb <= rnd(r_casb); r2_shca <= rnd(r_shca); r2_chsb <= rnd(r_chsb);
            r2_chcb <= rnd(r_chcb);
            r2_sa <= r1_sa; r2_sb <= r1_sb; r2_cb <= r1_cb;
        end
    end

    // stage 3: second products of the triple terms
    logic signed [P-1:0] r3_p1, r3_p2, r3_p3, r3_p4;
    logic signed [W-1:0] r3_chca, r3_shsb, r3_shcb, r3_cacb, r3_casb, r3_shca,
                         r3_chsb, r3_chcb, r3_sa;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_p1 <= P'(r2_chsa) * P'(r2_cb);
            r3_p2 <= P'(r2_chsa) * P'(r2_sb);
            r3_p3 <= P'(r2_shsa) * P'(r2_cb);
            r3_p4 <= P'(r2_shsa) * P'(r2_sb);
            r3_chca <= r2_chca; r3_shsb <= r2_shsb; r3_shcb <= r2_shcb;
            r3_cacb <= r2_cacb; r3_casb <= r2_casb; r3_shca <= r2_shca;
            r3_chsb <= r2_chsb; r3_chcb <= r2_chcb; r3_sa <= r2_sa;
        end
    end

    // stage 4: round, sum and clamp
    logic signed [W-1:0] v [9];
    always_comb begin
        v[0] = r3_chca;
        v[1] = r3_shsb - rnd(r3_p1);
        v[2] = rnd(r3_p2) + r3_shcb;
        v[3] = r3_sa;
        v[4] = r3_cacb;
        v[5] = -r3_casb;
        v[6] = -r3_shca;
        v[7] = rnd(r3_p3) + r3_chsb;
        v[8] = r3_chcb - rnd(r3_p4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++)
                o_ent[k*e2r_pkg::OutW +: e2r_pkg::OutW] <= to_out(v[k]);
        end
    end
endmodule

FILE: hw/rtl/euler_to_rotation_matrix.sv
// euler_to_rotation_matrix: top level, three cordic pipelines and the matrix stage
// depends on e2r_pkg, e2r_cordic, e2r_matrix
// Takes one Y-Z-X angle triple (Q2.13 rad) per cycle and returns the nine
// rotation matrix entries in Q1.14, clamped to plus or minus one. The pipeline
// has 31 cordic stages (reflection plus one per micro-rotation) and
// four product/rounding stages. The whole pipeline advances together whenever
// the output register is empty or being taken, so throughput is one item per
// cycle with no stall from the sink.
module euler_to_rotation_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [47:0]   s_axis_tdata,   // bank_angle, attitude_angle, heading_angle
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [143:0]  m_axis_tdata    // r00, r01, r02, r10, r11, r12, r20, r21, r22
);
    localparam int Lat = e2r_pkg::Steps + 1 + 4;

    logic           en;
    logic [Lat-1:0] r_vld;
    logic signed [e2r_pkg::CW-1:0] sb, cb, sa, ca, sh, ch;

    // pipeline moves when the last stage is free or being taken
    assign en = !r_vld[Lat-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[Lat-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end

    e2r_cordic u_bank (.i_clk(i_clk), .i_en(en), .i_ang(s_axis_tdata[15:0]),
                       .o_sin(sb), .o_cos(cb));
    e2r_cordic u_att  (.i_clk(i_clk), .i_en(en), .i_ang(s_axis_tdata[31:16]),
                       .o_sin(sa), .o_cos(ca));
    e2r_cordic u_head (.i_clk(i_clk), .i_en(en), .i_ang(s_axis_tdata[47:32]),
                       .o_sin(sh), .o_cos(ch));

    e2r_matrix u_mat (.i_clk(i_clk), .i_en(en), .i_sb(sb), .i_cb(cb), .i_sa(sa),
                      .i_ca(ca), .i_sh(sh), .i_ch(ch), .o_ent(m_axis_tdata));

    // output holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    // ready only refused when output is full
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("ready low with empty output");
    // entry valid bit follows s_axis_tvalid whenever the pipeline moves
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en |=> r_vld[0] == $past(s_axis_tvalid))
        else $error("valid bit lost at entry");
endmodule
